// ----- hw/rtl/mtfc_pkg.sv -----
package mtfc_pkg;

  // Default size of the peer table (entry 0 is the node itself)
  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  // Event kinds
  localparam logic [2:0] KIND_WAKEUP     = 3'd0;
  localparam logic [2:0] KIND_FLOOR_REQ  = 3'd1;
  localparam logic [2:0] KIND_STARTED    = 3'd2;
  localparam logic [2:0] KIND_LIST_REPLY = 3'd3;
  localparam logic [2:0] KIND_OWN_ACTION = 3'd4;
  localparam logic [2:0] KIND_PEER_ACTED = 3'd5;

  // Node status codes
  localparam logic [2:0] STAT_OFFLINE    = 3'd0;
  localparam logic [2:0] STAT_ONLINE     = 3'd1;
  localparam logic [2:0] STAT_IDLE       = 3'd2;
  localparam logic [2:0] STAT_SPEAK      = 3'd3;
  localparam logic [2:0] STAT_LISTEN     = 3'd4;
  localparam logic [2:0] STAT_REQUESTING = 3'd5;
  localparam logic [2:0] STAT_REQFROM    = 3'd6;

  // Send actions
  localparam logic [1:0] ACT_NONE      = 2'd0;
  localparam logic [1:0] ACT_LIST      = 2'd1;
  localparam logic [1:0] ACT_FLOOR_REQ = 2'd2;
  localparam logic [1:0] ACT_BROADCAST = 2'd3;

  // LED colour after reset: dim white
  localparam logic [11:0] LED_RESET = 12'h555;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN_REG,
    FSM_WRITE,
    FSM_SCAN_SPK,
    FSM_EMIT_RD,
    FSM_EMIT_LD,
    FSM_FINISH
  } fsm_e;

  typedef struct packed {
    logic [2:0]  own_status;
    logic [11:0] led;
    logic        led_write;
    logic [1:0]  send_action;
    logic [7:0]  send_target;
    logic [7:0]  entry_id;
    logic [2:0]  entry_status;
    logic        last;
    logic        handled;
  } result_t;

  // Colour of a status; bit 12 marks a status that has a colour
  function automatic logic [12:0] colour_of(logic [2:0] st);
    logic [12:0] c;
    case (st)
      STAT_OFFLINE:    c = 13'h1555;
      STAT_IDLE:       c = 13'h100F;
      STAT_SPEAK:      c = 13'h10F0;
      STAT_LISTEN:     c = 13'h1F00;
      STAT_REQUESTING: c = 13'h1F50;
      STAT_REQFROM:    c = 13'h1FF0;
      default:         c = 13'h0000;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/mesh_talk_floor_control_top.sv -----
// Floor control for one node of a talk mesh.
//
// Channels: the event channel (in_valid_i / in_ready_o) carries kind_i,
// peer_id_i and peer_status_i; the result channel (out_valid_o / out_ready_i)
// carries one result per event (one per table entry for a wakeup); the config
// channel (cfg_valid_i / cfg_ready_o) writes the node id and is always ready.
// The peer table sits in a single-port-read RAM; entry 0 (own id and
// status) lives in registers. Each table scan reads one entry per cycle.
// Steps from event accept to result, with N table entries:
//   floor request, started speaking, peer acted, unknown: no table pass
//   own action: speaker scan
//   list reply: register scan, write back, speaker scan
//   wakeup: register scan, write back, then N results, each a read and
//   then a load of the output register.
// A new event is taken once the last result of the current one sits in the
// output register. A stalled receiver holds the output register and the
// sequencer waits on it. Reset clears the per-entry valid bits at once,
// so invalid entries read as id 0, offline; no clearing pass is needed.
module mesh_talk_floor_control_top #(
  parameter int unsigned TABLE_ENTRIES = mtfc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] kind_i,
  input  logic [7:0] peer_id_i,
  input  logic [2:0] peer_status_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] own_status_o,
  output logic [3:0] led_red_o,
  output logic [3:0] led_green_o,
  output logic [3:0] led_blue_o,
  output logic       led_write_o,
  output logic [1:0] send_action_o,
  output logic [7:0] send_target_o,
  output logic [7:0] entry_id_o,
  output logic [2:0] entry_status_o,
  output logic       last_o,
  output logic       handled_o
);
  import mtfc_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_END  = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0] CNT_LAST = CW'(TABLE_ENTRIES - 1);

  fsm_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0]    kind_q;
  logic [7:0]    pid_q;
  logic [2:0]    pst_q;
  logic [7:0]    own_id_q;
  logic [2:0]    own_q, own_d;
  logic [11:0]   led_q, led_d;

  logic [TABLE_ENTRIES-1:0] valid_q;

  logic          match_found_q, match_found_d;
  logic [AW-1:0] match_idx_q, match_idx_d;
  logic          off_found_q, off_found_d;
  logic [AW-1:0] off_idx_q, off_idx_d;
  logic          sp_found_q, sp_found_d;
  logic [7:0]    sp_id_q, sp_id_d;

  result_t out_q, out_d;
  logic    out_valid_q, out_valid_d;
  logic    out_free;
  logic    in_accept;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [10:0]   ram_wdata, ram_rdata;

  logic [AW-1:0] eval_idx;
  logic [7:0]    eval_id;
  logic [2:0]    eval_st;
  logic          eval_en;

  logic          do_apply;
  logic [2:0]    new_st;
  logic [12:0]   new_colour;
  logic          led_wr;
  logic [1:0]    fin_act;
  logic [7:0]    fin_tgt;
  logic          fin_handled;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == FSM_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Peer table memory: {id, status} per entry
  mtfc_ram #(
    .WIDTH (11),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entry under evaluation was addressed in the previous cycle
  assign eval_idx = cnt_q[AW-1:0] - AW'(1);
  assign eval_en  = (cnt_q >= CW'(2));
  assign eval_id  = valid_q[eval_idx] ? ram_rdata[10:3] : 8'd0;
  assign eval_st  = valid_q[eval_idx] ? ram_rdata[2:0] : STAT_OFFLINE;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_accept) begin
          if (kind_i == KIND_WAKEUP || kind_i == KIND_LIST_REPLY) begin
            state_d = FSM_SCAN_REG;
          end else if (kind_i == KIND_OWN_ACTION) begin
            state_d = FSM_SCAN_SPK;
          end else begin
            state_d = FSM_FINISH;
          end
        end
      end
      FSM_SCAN_REG: begin
        if (cnt_q == CNT_END) state_d = FSM_WRITE;
      end
      FSM_WRITE: begin
        state_d = (kind_q == KIND_WAKEUP) ? FSM_EMIT_RD : FSM_SCAN_SPK;
      end
      FSM_SCAN_SPK: begin
        if (cnt_q == CNT_END) state_d = FSM_FINISH;
      end
      FSM_EMIT_RD: begin
        state_d = FSM_EMIT_LD;
      end
      FSM_EMIT_LD: begin
        if (out_free) state_d = (cnt_q == CNT_LAST) ? FSM_IDLE : FSM_EMIT_RD;
      end
      FSM_FINISH: begin
        if (out_free) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Status transition of a finishing event
  always_comb begin
    do_apply    = 1'b0;
    new_st      = own_q;
    fin_act     = ACT_NONE;
    fin_tgt     = 8'd0;
    fin_handled = 1'b1;
    case (kind_q)
      KIND_FLOOR_REQ: begin
        if (own_q == STAT_SPEAK) begin
          do_apply = 1'b1;
          new_st   = STAT_REQFROM;
        end else if (own_q == STAT_IDLE) begin
          do_apply = 1'b1;
          new_st   = STAT_LISTEN;
        end
      end
      KIND_STARTED: begin
        if (own_q == STAT_SPEAK || own_q == STAT_IDLE) begin
          do_apply = 1'b1;
          new_st   = STAT_LISTEN;
        end
      end
      KIND_LIST_REPLY: begin
        do_apply = 1'b1;
        new_st   = sp_found_q ? STAT_LISTEN : STAT_IDLE;
      end
      KIND_OWN_ACTION: begin
        if (own_q == STAT_IDLE) begin
          if (sp_found_q) begin
            fin_act = ACT_FLOOR_REQ;
            fin_tgt = sp_id_q;
          end else begin
            do_apply = 1'b1;
            new_st   = STAT_SPEAK;
            fin_act  = ACT_BROADCAST;
          end
        end
      end
      KIND_PEER_ACTED: begin
        do_apply = 1'b1;
        if (own_q == STAT_IDLE) new_st = STAT_LISTEN;
        else if (own_q == STAT_SPEAK) new_st = STAT_REQFROM;
        else if (own_q == STAT_REQUESTING) new_st = STAT_SPEAK;
      end
      default: fin_handled = 1'b0;
    endcase
    new_colour = colour_of(new_st);
    led_wr     = do_apply && new_colour[12] && (new_colour[11:0] != led_q);
  end

  // Datapath, memory control and result loading
  always_comb begin
    cnt_d         = cnt_q;
    own_d         = own_q;
    led_d         = led_q;
    match_found_d = match_found_q;
    match_idx_d   = match_idx_q;
    off_found_d   = off_found_q;
    off_idx_d     = off_idx_q;
    sp_found_d    = sp_found_q;
    sp_id_d       = sp_id_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    ram_we        = 1'b0;
    ram_waddr     = match_found_q ? match_idx_q : off_idx_q;
    ram_wdata     = {pid_q, (kind_q == KIND_WAKEUP) ? STAT_IDLE : pst_q};
    ram_re        = 1'b0;
    ram_raddr     = cnt_q[AW-1:0];
    case (state_q)
      FSM_IDLE: begin
        if (in_accept) begin
          cnt_d         = CW'(1);
          match_found_d = 1'b0;
          off_found_d   = 1'b0;
          sp_found_d    = 1'b0;
        end
      end
      FSM_SCAN_REG: begin
        // Look for the matching id and the first offline entry
        if (cnt_q != CNT_END) begin
          ram_re = 1'b1;
          cnt_d  = cnt_q + CW'(1);
        end
        if (eval_en) begin
          if (!match_found_q && eval_id == pid_q) begin
            match_found_d = 1'b1;
            match_idx_d   = eval_idx;
          end
          if (!off_found_q && eval_st == STAT_OFFLINE) begin
            off_found_d = 1'b1;
            off_idx_d   = eval_idx;
          end
        end
      end
      FSM_WRITE: begin
        ram_we = match_found_q || off_found_q;
        cnt_d  = (kind_q == KIND_WAKEUP) ? CW'(0) : CW'(1);
      end
      FSM_SCAN_SPK: begin
        // Find the first peer that speaks
        if (cnt_q != CNT_END) begin
          ram_re = 1'b1;
          cnt_d  = cnt_q + CW'(1);
        end
        if (eval_en && !sp_found_q && eval_st == STAT_SPEAK) begin
          sp_found_d = 1'b1;
          sp_id_d    = eval_id;
        end
      end
      FSM_EMIT_RD: begin
        ram_re = (cnt_q != CW'(0));
      end
      FSM_EMIT_LD: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.own_status  = own_q;
          out_d.led         = led_q;
          out_d.led_write   = 1'b0;
          out_d.send_action = ACT_LIST;
          out_d.send_target = pid_q;
          if (cnt_q == CW'(0)) begin
            out_d.entry_id     = own_id_q;
            out_d.entry_status = own_q;
          end else if (valid_q[cnt_q[AW-1:0]]) begin
            out_d.entry_id     = ram_rdata[10:3];
            out_d.entry_status = ram_rdata[2:0];
          end else begin
            out_d.entry_id     = 8'd0;
            out_d.entry_status = STAT_OFFLINE;
          end
          out_d.last    = (cnt_q == CNT_LAST);
          out_d.handled = 1'b1;
          cnt_d         = cnt_q + CW'(1);
        end
      end
      FSM_FINISH: begin
        if (out_free) begin
          if (do_apply) own_d = new_st;
          if (led_wr) led_d = new_colour[11:0];
          out_valid_d        = 1'b1;
          out_d.own_status   = do_apply ? new_st : own_q;
          out_d.led          = led_wr ? new_colour[11:0] : led_q;
          out_d.led_write    = led_wr;
          out_d.send_action  = fin_act;
          out_d.send_target  = fin_tgt;
          out_d.entry_id     = 8'd0;
          out_d.entry_status = STAT_OFFLINE;
          out_d.last         = 1'b1;
          out_d.handled      = fin_handled;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= FSM_IDLE;
      cnt_q         <= '0;
      own_q         <= STAT_OFFLINE;
      led_q         <= LED_RESET;
      own_id_q      <= 8'd0;
      valid_q       <= '0;
      out_valid_q   <= 1'b0;
      match_found_q <= 1'b0;
      off_found_q   <= 1'b0;
      sp_found_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      own_q         <= own_d;
      led_q         <= led_d;
      out_valid_q   <= out_valid_d;
      match_found_q <= match_found_d;
      off_found_q   <= off_found_d;
      sp_found_q    <= sp_found_d;
      if (cfg_valid_i && cfg_ready_o) own_id_q <= cfg_data_i;
      if (ram_we) valid_q[ram_waddr] <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q <= kind_i;
      pid_q  <= peer_id_i;
      pst_q  <= peer_status_i;
    end
    match_idx_q <= match_idx_d;
    off_idx_q   <= off_idx_d;
    sp_id_q     <= sp_id_d;
    out_q       <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign own_status_o   = out_q.own_status;
  assign led_red_o      = out_q.led[11:8];
  assign led_green_o    = out_q.led[7:4];
  assign led_blue_o     = out_q.led[3:0];
  assign led_write_o    = out_q.led_write;
  assign send_action_o  = out_q.send_action;
  assign send_target_o  = out_q.send_target;
  assign entry_id_o     = out_q.entry_id;
  assign entry_status_o = out_q.entry_status;
  assign last_o         = out_q.last;
  assign handled_o      = out_q.handled;

  // An accepted event always leaves the idle state
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != FSM_IDLE)
    else $error("event accepted but sequencer stayed idle");

  // Scan counter never runs past the table size
  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_END)
    else $error("table counter out of range");

  // Emission only addresses real entries
  a_emit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_EMIT_LD || state_q == FSM_EMIT_RD) |-> cnt_q < CNT_END)
    else $error("emission index out of range");

  // A waiting result is never overwritten
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("pending result lost");

  // Memory writes happen only in the write-back step
  a_write_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == FSM_WRITE && (kind_q == KIND_WAKEUP ||
                                         kind_q == KIND_LIST_REPLY)))
    else $error("table written outside write-back");

endmodule

// ----- hw/rtl/mtfc_ram.sv -----
module mtfc_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
